/* rtl/core/crbm_pkg.sv */
// Shared types and constants for the clipped rectangle block move.
package crbm_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW         = $clog2(DEPTH);
    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int YW         = $clog2(MAX_HEIGHT);
    localparam int SCR_W      = 7;
    localparam int CRD_W      = 19;
    localparam int PIX_W      = 16;
    localparam int POS_W      = 16;
    localparam int CLIP_PW    = 15;
    localparam int CLIP_SW    = 17;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [SCR_W-1:0] SCR_RST = SCR_W'(64);

    typedef logic signed [CRD_W-1:0] t_crd;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_MOVE  = 2'd2
    } t_req_type;

    typedef enum logic {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SIZE,
        S_TGT,
        S_TSZ,
        S_BASE,
        S_PREP,
        S_COPY,
        S_DRAIN,
        S_PIX,
        S_FIN
    } t_state;

    typedef struct packed {
        logic accept;
        logic decode;
        logic size;
        logic tgt;
        logic tsz;
        logic base;
        logic prep;
        logic issue;
        logic pix;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] req_type;
        logic       src_ok;
        logic       move_ok;
        logic       last;
        logic       out_blocked;
    } t_dp_sts;

endpackage

/* rtl/core/crbm_ctrl.sv */
// Sequencer for pixel requests and the clip, setup and copy phases of a move.
module crbm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  crbm_pkg::t_dp_sts i_sts,
    output logic              o_in_stall,
    output crbm_pkg::t_dp_cmd o_cmd
);
    import crbm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                case (i_sts.req_type) inside
                    REQ_MOVE:            n_state = S_SIZE;
                    REQ_WRITE, REQ_READ: n_state = S_PIX;
                    default:             n_state = S_FIN;
                endcase
            end
            S_SIZE: begin
                o_cmd.size = 1'b1;
                n_state    = S_TGT;
            end
            S_TGT: begin
                if (i_sts.src_ok) begin
                    o_cmd.tgt = 1'b1;
                    n_state   = S_TSZ;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_TSZ: begin
                o_cmd.tsz = 1'b1;
                n_state   = S_BASE;
            end
            S_BASE: begin
                if (i_sts.move_ok) begin
                    o_cmd.base = 1'b1;
                    n_state    = S_PREP;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_COPY;
            end
            S_COPY: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last pending write retires here
                n_state = S_FIN;
            end
            S_PIX: begin
                o_cmd.pix = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (!i_sts.out_blocked) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/crbm_dp.sv */
// Datapath: request registers, clip arithmetic, copy address counters, frame store, result word.
module crbm_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  crbm_pkg::t_dp_cmd                      i_cmd,
    output crbm_pkg::t_dp_sts                      o_sts,
    input  logic [crbm_pkg::SCR_W-1:0]             i_scr_width,
    input  logic [crbm_pkg::SCR_W-1:0]             i_scr_height,
    input  logic [1:0]                             i_req_type,
    input  logic signed [crbm_pkg::POS_W-1:0]      i_pos_x,
    input  logic signed [crbm_pkg::POS_W-1:0]      i_pos_y,
    input  logic signed [crbm_pkg::POS_W-1:0]      i_rect_width,
    input  logic signed [crbm_pkg::POS_W-1:0]      i_rect_height,
    input  logic signed [crbm_pkg::POS_W-1:0]      i_dest_x,
    input  logic signed [crbm_pkg::POS_W-1:0]      i_dest_y,
    input  logic [crbm_pkg::PIX_W-1:0]             i_pixel_in,
    input  logic                                   i_out_stall,
    output logic                                   o_out_valid,
    output logic [crbm_pkg::PIX_W-1:0]             o_pixel_out,
    output logic                                   o_move_done,
    output logic [crbm_pkg::CLIP_PW-1:0]           o_clip_x,
    output logic [crbm_pkg::CLIP_PW-1:0]           o_clip_y,
    output logic signed [crbm_pkg::CLIP_SW-1:0]    o_clip_width,
    output logic signed [crbm_pkg::CLIP_SW-1:0]    o_clip_height
);
    import crbm_pkg::*;

    // request word
    logic [1:0]              r_type;
    logic signed [POS_W-1:0] r_px, r_py, r_rw, r_rh, r_dx, r_dy;
    logic [PIX_W-1:0]        r_pin;

    // clip pipeline
    t_crd r_cx, r_cy, r_rbx, r_rby;
    t_crd r_cw, r_ch, r_tx, r_ty;
    t_crd r_tre, r_tbe, r_tw, r_th;
    logic r_src_ok;

    // pixel access
    logic          r_pix_ok;
    logic [AW-1:0] r_paddr;

    // copy setup and counters
    logic [AW-1:0] r_sbase, r_dbase, r_loff;
    logic [XW-1:0] r_twm1;
    logic [YW-1:0] r_thm1;
    logic          r_desc;
    logic [AW-1:0] r_srow, r_drow;
    logic [XW-1:0] r_col;
    logic [YW-1:0] r_rows;
    logic          r_wpend;
    logic [AW-1:0] r_wdst;

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    logic r_ovalid;

    logic [SCR_W-1:0] sw_e, sh_e;
    t_crd             sw_c, sh_c;
    t_crd             px_c, py_c, dx_c, dy_c;
    t_crd             sum_x, sum_y, tsum_x, tsum_y;
    logic [YW-1:0]    thm1_c;
    logic             desc_c;
    logic             col_end;
    logic             move_ok;
    logic [AW-1:0]    src_addr, dst_addr;
    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [PIX_W-1:0] mem_wdata;

    // registers above the panel limit saturate to it
    assign sw_e = (32'(i_scr_width) > MAX_WIDTH) ? SCR_W'(MAX_WIDTH) : i_scr_width;
    assign sh_e = (32'(i_scr_height) > MAX_HEIGHT) ? SCR_W'(MAX_HEIGHT) : i_scr_height;
    assign sw_c = t_crd'({1'b0, sw_e});
    assign sh_c = t_crd'({1'b0, sh_e});

    assign px_c = t_crd'(r_px);
    assign py_c = t_crd'(r_py);
    assign dx_c = t_crd'(r_dx);
    assign dy_c = t_crd'(r_dy);

    assign sum_x  = px_c + t_crd'(r_rw);
    assign sum_y  = py_c + t_crd'(r_rh);
    assign tsum_x = dx_c + r_cw;
    assign tsum_y = dy_c + r_ch;

    assign thm1_c  = YW'(r_th - t_crd'(1));
    assign desc_c  = r_dbase > r_sbase;
    assign move_ok = r_src_ok && (r_tw > t_crd'(0)) && (r_th > t_crd'(0));

    assign col_end  = r_desc ? (r_col == '0) : (r_col == r_twm1);
    assign src_addr = r_srow + AW'(r_col);
    assign dst_addr = r_drow + AW'(r_col);

    assign o_sts.req_type    = r_type;
    assign o_sts.src_ok      = r_src_ok;
    assign o_sts.move_ok     = move_ok;
    assign o_sts.last        = col_end && (r_rows == '0);
    assign o_sts.out_blocked = r_ovalid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_type <= i_req_type;
            r_px   <= i_pos_x;
            r_py   <= i_pos_y;
            r_rw   <= i_rect_width;
            r_rh   <= i_rect_height;
            r_dx   <= i_dest_x;
            r_dy   <= i_dest_y;
            r_pin  <= i_pixel_in;
        end
        if (i_cmd.decode) begin
            r_cx     <= r_px[POS_W-1] ? t_crd'(0) : px_c;
            r_cy     <= r_py[POS_W-1] ? t_crd'(0) : py_c;
            r_rbx    <= (sum_x < sw_c) ? sum_x : sw_c;
            r_rby    <= (sum_y < sh_c) ? sum_y : sh_c;
            r_pix_ok <= !r_px[POS_W-1] && !r_py[POS_W-1] && (px_c < sw_c) && (py_c < sh_c);
            r_paddr  <= AW'(r_py[YW-1:0] * sw_e) + AW'(r_px[XW-1:0]);
        end
        if (i_cmd.size) begin
            r_cw     <= r_rbx - r_cx;
            r_ch     <= r_rby - r_cy;
            r_src_ok <= (r_cx < r_rbx) && (r_cy < r_rby);
            r_tx     <= r_dx[POS_W-1] ? t_crd'(0) : dx_c;
            r_ty     <= r_dy[POS_W-1] ? t_crd'(0) : dy_c;
        end
        if (i_cmd.tgt) begin
            r_tre <= (tsum_x < sw_c) ? tsum_x : sw_c;
            r_tbe <= (tsum_y < sh_c) ? tsum_y : sh_c;
        end
        if (i_cmd.tsz) begin
            r_tw <= r_tre - r_tx;
            r_th <= r_tbe - r_ty;
        end
        if (i_cmd.base) begin
            r_sbase <= AW'(r_cy[YW-1:0] * sw_e) + AW'(r_cx[XW-1:0]);
            r_dbase <= AW'(r_ty[YW-1:0] * sw_e) + AW'(r_tx[XW-1:0]);
            r_loff  <= AW'(thm1_c * sw_e);
            r_twm1  <= XW'(r_tw - t_crd'(1));
            r_thm1  <= thm1_c;
        end
        // target above the source in memory: walk both blocks from the far end
        if (i_cmd.prep) begin
            r_desc <= desc_c;
            r_srow <= desc_c ? r_sbase + r_loff : r_sbase;
            r_drow <= desc_c ? r_dbase + r_loff : r_dbase;
            r_col  <= desc_c ? r_twm1 : '0;
            r_rows <= r_thm1;
        end
        if (i_cmd.issue) begin
            r_wdst <= dst_addr;
            if (col_end) begin
                r_rows <= r_rows - YW'(1);
                r_col  <= r_desc ? r_twm1 : '0;
                r_srow <= r_desc ? r_srow - AW'(sw_e) : r_srow + AW'(sw_e);
                r_drow <= r_desc ? r_drow - AW'(sw_e) : r_drow + AW'(sw_e);
            end else begin
                r_col <= r_desc ? r_col - XW'(1) : r_col + XW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpend <= 1'b0;
        end else begin
            r_wpend <= i_cmd.issue;
        end
    end

    // frame store: one write port, one registered read port
    assign mem_we    = r_wpend || (i_cmd.pix && (r_type == REQ_WRITE) && r_pix_ok);
    assign mem_waddr = r_wpend ? r_wdst : r_paddr;
    assign mem_wdata = r_wpend ? r_rdata : r_pin;
    assign mem_re    = i_cmd.issue || i_cmd.pix;
    assign mem_raddr = i_cmd.issue ? src_addr : r_paddr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_pixel_out <= ((r_type == REQ_READ) && r_pix_ok) ? r_rdata : '0;
            o_move_done <= (r_type == REQ_MOVE) && move_ok;
            if (r_type == REQ_MOVE) begin
                o_clip_x      <= r_cx[CLIP_PW-1:0];
                o_clip_y      <= r_cy[CLIP_PW-1:0];
                o_clip_width  <= r_cw[CLIP_SW-1:0];
                o_clip_height <= r_ch[CLIP_SW-1:0];
            end else begin
                o_clip_x      <= '0;
                o_clip_y      <= '0;
                o_clip_width  <= '0;
                o_clip_height <= '0;
            end
        end
    end

    assign o_out_valid = r_ovalid;

endmodule

/* rtl/core/clipped_rect_block_move_top.sv */
// Top level: screen size registers on the APB port, sequencer and datapath.
//
//  channel   direction  handshake                 word
//  request   in         i_in_valid / o_in_stall   i_req_type .. i_pixel_in
//  result    out        o_out_valid / i_out_stall o_pixel_out .. o_clip_height
//  config    in         APB psel/penable/pwrite   screen_width, screen_height
//
// Pixel write or read: decode, the pixel access, then the result; an unused type
// goes from decode straight to the result. Move: clip and setup states, then the
// copy, skipped when the source or the target clips away; the copy moves one pixel
// a cycle through the frame store's read and write ports.
// The block returns to idle and takes a new request once the previous result is registered.
// Reset sets both screen registers to 64; the frame store is not cleared.
// A stalled result holds; the block then waits before loading the next one.
module clipped_rect_block_move_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [1:0]                             i_req_type,
    input  logic signed [crbm_pkg::POS_W-1:0]      i_pos_x,
    input  logic signed [crbm_pkg::POS_W-1:0]      i_pos_y,
    input  logic signed [crbm_pkg::POS_W-1:0]      i_rect_width,
    input  logic signed [crbm_pkg::POS_W-1:0]      i_rect_height,
    input  logic signed [crbm_pkg::POS_W-1:0]      i_dest_x,
    input  logic signed [crbm_pkg::POS_W-1:0]      i_dest_y,
    input  logic [crbm_pkg::PIX_W-1:0]             i_pixel_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [crbm_pkg::PIX_W-1:0]             o_pixel_out,
    output logic                                   o_move_done,
    output logic [crbm_pkg::CLIP_PW-1:0]           o_clip_x,
    output logic [crbm_pkg::CLIP_PW-1:0]           o_clip_y,
    output logic signed [crbm_pkg::CLIP_SW-1:0]    o_clip_width,
    output logic signed [crbm_pkg::CLIP_SW-1:0]    o_clip_height,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [crbm_pkg::PADDR_W-1:0]           paddr,
    input  logic [crbm_pkg::PDATA_W-1:0]           pwdata,
    output logic [crbm_pkg::PDATA_W-1:0]           prdata,
    output logic                                   pready
);
    import crbm_pkg::*;

    logic [SCR_W-1:0] r_scr_width;
    logic [SCR_W-1:0] r_scr_height;
    logic             cfg_wr;
    t_reg_idx         reg_idx;
    t_dp_cmd          cmd;
    t_dp_sts          sts;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_width  <= SCR_RST;
            r_scr_height <= SCR_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_SCREEN_WIDTH:  r_scr_width  <= pwdata[SCR_W-1:0];
                REG_SCREEN_HEIGHT: r_scr_height <= pwdata[SCR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_SCREEN_WIDTH:  prdata = PDATA_W'(r_scr_width);
            REG_SCREEN_HEIGHT: prdata = PDATA_W'(r_scr_height);
            default:           prdata = '0;
        endcase
    end

    crbm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    crbm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_scr_width   (r_scr_width),
        .i_scr_height  (r_scr_height),
        .i_req_type    (i_req_type),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_dest_x      (i_dest_x),
        .i_dest_y      (i_dest_y),
        .i_pixel_in    (i_pixel_in),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_pixel_out   (o_pixel_out),
        .o_move_done   (o_move_done),
        .o_clip_x      (o_clip_x),
        .o_clip_y      (o_clip_y),
        .o_clip_width  (o_clip_width),
        .o_clip_height (o_clip_height)
    );

    // one request in flight: busy right after a word is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while previous one still in flight");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> !(o_out_valid && i_out_stall))
        else $error("result loaded over a stalled result");

    // a completed move always reports a non-empty clipped source
    a_done_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_move_done) |-> (o_clip_width > 0) && (o_clip_height > 0))
        else $error("move reported done with empty clipped source");

    // copy only runs with a valid target block
    a_copy_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.issue |-> sts.move_ok && sts.src_ok)
        else $error("copy running without a valid block");

endmodule

/* tb/crbm_result_checker.sv */
// Result checker: tracks screen registers and frame contents, predicts and compares results.
module crbm_result_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    input  logic                                   o_in_stall,
    input  logic [1:0]                             i_req_type,
    input  logic signed [crbm_pkg::POS_W-1:0]      i_pos_x,
    input  logic signed [crbm_pkg::POS_W-1:0]      i_pos_y,
    input  logic signed [crbm_pkg::POS_W-1:0]      i_rect_width,
    input  logic signed [crbm_pkg::POS_W-1:0]      i_rect_height,
    input  logic signed [crbm_pkg::POS_W-1:0]      i_dest_x,
    input  logic signed [crbm_pkg::POS_W-1:0]      i_dest_y,
    input  logic [crbm_pkg::PIX_W-1:0]             i_pixel_in,
    input  logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    input  logic [crbm_pkg::PIX_W-1:0]             o_pixel_out,
    input  logic                                   o_move_done,
    input  logic [crbm_pkg::CLIP_PW-1:0]           o_clip_x,
    input  logic [crbm_pkg::CLIP_PW-1:0]           o_clip_y,
    input  logic signed [crbm_pkg::CLIP_SW-1:0]    o_clip_width,
    input  logic signed [crbm_pkg::CLIP_SW-1:0]    o_clip_height,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [crbm_pkg::PADDR_W-1:0]           paddr,
    input  logic [crbm_pkg::PDATA_W-1:0]           pwdata,
    input  logic                                   pready,
    output int                                     o_fail_count,
    output int                                     o_pending
);
    import crbm_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0]          pixel;
        logic                      done;
        logic [CLIP_PW-1:0]        clip_x;
        logic [CLIP_PW-1:0]        clip_y;
        logic signed [CLIP_SW-1:0] clip_w;
        logic signed [CLIP_SW-1:0] clip_h;
    } t_move_result;

    logic [PIX_W-1:0] frame_copy [DEPTH];
    logic [PIX_W-1:0] snap_buf [DEPTH];
    logic [SCR_W-1:0] scr_w;
    logic [SCR_W-1:0] scr_h;
    t_move_result     expected_results [$];
    t_move_result     got;
    t_move_result     want;
    int               fail_total = 0;

    function automatic t_move_result apply_request(input logic [1:0] kind,
                                                   input int px, input int py,
                                                   input int rw, input int rh,
                                                   input int dx, input int dy,
                                                   input logic [PIX_W-1:0] pin);
        t_move_result r;
        int sw, sh, cx, cy, rbx, rby, cw, ch, tx, ty, tw, th;
        bit on_scr;
        r = '0;
        // registers above the store size saturate
        sw = (scr_w > MAX_WIDTH) ? MAX_WIDTH : int'(scr_w);
        sh = (scr_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(scr_h);
        on_scr = px >= 0 && py >= 0 && px < sw && py < sh;
        case (kind)
            REQ_WRITE: begin
                if (on_scr)
                    frame_copy[py * sw + px] = pin;
            end
            REQ_READ: begin
                if (on_scr)
                    r.pixel = frame_copy[py * sw + px];
            end
            REQ_MOVE: begin
                cx  = (px > 0) ? px : 0;
                cy  = (py > 0) ? py : 0;
                rbx = (px + rw < sw) ? px + rw : sw;
                rby = (py + rh < sh) ? py + rh : sh;
                cw  = rbx - cx;
                ch  = rby - cy;
                r.clip_x = cx[CLIP_PW-1:0];
                r.clip_y = cy[CLIP_PW-1:0];
                r.clip_w = cw[CLIP_SW-1:0];
                r.clip_h = ch[CLIP_SW-1:0];
                if (cx < rbx && cy < rby) begin
                    tx = (dx > 0) ? dx : 0;
                    ty = (dy > 0) ? dy : 0;
                    tw = ((dx + cw < sw) ? dx + cw : sw) - tx;
                    th = ((dy + ch < sh) ? dy + ch : sh) - ty;
                    if (tw > 0 && th > 0) begin
                        // read the whole block first so overlap cannot corrupt it
                        for (int j = 0; j < th; j++)
                            for (int i = 0; i < tw; i++)
                                snap_buf[j * tw + i] = frame_copy[(cy + j) * sw + cx + i];
                        for (int j = 0; j < th; j++)
                            for (int i = 0; i < tw; i++)
                                frame_copy[(ty + j) * sw + tx + i] = snap_buf[j * tw + i];
                        r.done = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scr_w = SCR_RST;
            scr_h = SCR_RST;
            expected_results.delete();
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = {o_pixel_out, o_move_done, o_clip_x, o_clip_y,
                       o_clip_width, o_clip_height};
                if (expected_results.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("checker: unexpected result word %p", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display({"checker: mismatch exp pix %h done %b clip %0d,%0d ",
                                      "size %0d x %0d / got pix %h done %b clip %0d,%0d ",
                                      "size %0d x %0d"},
                                     want.pixel, want.done, want.clip_x, want.clip_y,
                                     want.clip_w, want.clip_h,
                                     got.pixel, got.done, got.clip_x, got.clip_y,
                                     got.clip_w, got.clip_h);
                    end
                end
            end
            if (i_in_valid && !o_in_stall)
                expected_results.push_back(apply_request(i_req_type, i_pos_x, i_pos_y,
                                                         i_rect_width, i_rect_height,
                                                         i_dest_x, i_dest_y, i_pixel_in));
            if (psel && penable && pwrite && pready) begin
                case (paddr[PADDR_W-1:2])
                    REG_SCREEN_WIDTH:  scr_w = pwdata[SCR_W-1:0];
                    REG_SCREEN_HEIGHT: scr_h = pwdata[SCR_W-1:0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_results.size();
    end

endmodule

/* tb/clipped_rect_block_move_top_tb.sv */
// Testbench top: pixel, move and screen register stimulus for the block move, and verdict.
module clipped_rect_block_move_top_tb;
    import crbm_pkg::*;

    localparam logic [1:0] REQ_UNUSED     = 2'd3;
    localparam int         WATCHDOG_LIMIT = 20000;
    localparam int         NUM_PHASES     = 7;
    localparam int         ITEMS_PER_PHASE = 14;
    localparam int         SEED_PIXELS    = 8;

    typedef struct {
        logic [1:0]              kind;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] rw;
        logic signed [POS_W-1:0] rh;
        logic signed [POS_W-1:0] dx;
        logic signed [POS_W-1:0] dy;
        logic [PIX_W-1:0]        pix;
    } t_request;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic [1:0]                i_req_type;
    logic signed [POS_W-1:0]   i_pos_x;
    logic signed [POS_W-1:0]   i_pos_y;
    logic signed [POS_W-1:0]   i_rect_width;
    logic signed [POS_W-1:0]   i_rect_height;
    logic signed [POS_W-1:0]   i_dest_x;
    logic signed [POS_W-1:0]   i_dest_y;
    logic [PIX_W-1:0]          i_pixel_in;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [PIX_W-1:0]          o_pixel_out;
    logic                      o_move_done;
    logic [CLIP_PW-1:0]        o_clip_x;
    logic [CLIP_PW-1:0]        o_clip_y;
    logic signed [CLIP_SW-1:0] o_clip_width;
    logic signed [CLIP_SW-1:0] o_clip_height;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [PADDR_W-1:0]        paddr;
    logic [PDATA_W-1:0]        pwdata;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;

    int fail_count;
    int pending;
    int send_idle_pct = 32;
    int recv_idle_pct = 77;
    int idle_cycles   = 0;
    int cfg_w [NUM_PHASES] = '{64, 127, 0, 12, 1, 37, 64};
    int cfg_h [NUM_PHASES] = '{64, 127, 15, 0, 1, 23, 50};

    clipped_rect_block_move_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_req_type(i_req_type), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y),
        .i_rect_width(i_rect_width), .i_rect_height(i_rect_height),
        .i_dest_x(i_dest_x), .i_dest_y(i_dest_y), .i_pixel_in(i_pixel_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_pixel_out(o_pixel_out), .o_move_done(o_move_done),
        .o_clip_x(o_clip_x), .o_clip_y(o_clip_y),
        .o_clip_width(o_clip_width), .o_clip_height(o_clip_height),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    crbm_result_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_req_type(i_req_type), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y),
        .i_rect_width(i_rect_width), .i_rect_height(i_rect_height),
        .i_dest_x(i_dest_x), .i_dest_y(i_dest_y), .i_pixel_in(i_pixel_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_pixel_out(o_pixel_out), .o_move_done(o_move_done),
        .o_clip_x(o_clip_x), .o_clip_y(o_clip_y),
        .o_clip_width(o_clip_width), .o_clip_height(o_clip_height),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // counts cycles in which no word moves on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic t_request mk_req(input logic [1:0] kind, input int px, input int py,
                                        input int rw, input int rh, input int dx,
                                        input int dy, input int pix);
        t_request r;
        r.kind = kind;
        r.px   = POS_W'(px);
        r.py   = POS_W'(py);
        r.rw   = POS_W'(rw);
        r.rh   = POS_W'(rh);
        r.dx   = POS_W'(dx);
        r.dy   = POS_W'(dy);
        r.pix  = PIX_W'(pix);
        return r;
    endfunction

    // mostly near the screen, now and then anywhere in the 16-bit range
    function automatic int pick_coord(input int span);
        if ($urandom_range(0, 6) == 0)
            return int'($signed(POS_W'($urandom)));
        return int'($urandom_range(0, span + 15)) - 8;
    endfunction

    function automatic int pick_size();
        int pick;
        pick = $urandom_range(0, 29);
        if (pick == 0)
            return MAX_WIDTH;
        if (pick < 3)
            return int'($signed(POS_W'($urandom)));
        if (pick < 5)
            return -int'($urandom_range(0, 4));
        return $urandom_range(1, 12);
    endfunction

    function automatic t_request random_req(input int span_w, input int span_h);
        int pick;
        logic [1:0] kind;
        pick = $urandom_range(0, 19);
        if (pick < 6)
            kind = REQ_WRITE;
        else if (pick < 11)
            kind = REQ_READ;
        else if (pick < 19)
            kind = REQ_MOVE;
        else
            kind = REQ_UNUSED;
        return mk_req(kind, pick_coord(span_w), pick_coord(span_h), pick_size(),
                      pick_size(), pick_coord(span_w), pick_coord(span_h), $urandom);
    endfunction

    task automatic send_req(input t_request r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_req_type    <= r.kind;
        i_pos_x       <= r.px;
        i_pos_y       <= r.py;
        i_rect_width  <= r.rw;
        i_rect_height <= r.rh;
        i_dest_x      <= r.dx;
        i_dest_y      <= r.dy;
        i_pixel_in    <= r.pix;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (16) @(posedge i_clk);
    endtask

    // upper data bits are don't-care noise
    task automatic write_screen_reg(input t_reg_idx idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(idx));
        pwdata  <= ($urandom & ~32'h7F) | (value & 32'h7F);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_out_stall   <= 1'b0;
        i_req_type    <= REQ_WRITE;
        i_pos_x       <= '0;
        i_pos_y       <= '0;
        i_rect_width  <= '0;
        i_rect_height <= '0;
        i_dest_x      <= '0;
        i_dest_y      <= '0;
        i_pixel_in    <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // store is undefined after reset: seed a short run of pixels, then spread
        // it over every entry with doubling moves before anything reads it
        for (int x = 0; x < SEED_PIXELS; x++)
            send_req(mk_req(REQ_WRITE, x, 0, 0, 0, 0, 0, $urandom));
        for (int s = SEED_PIXELS; s < MAX_WIDTH; s = s * 2)
            send_req(mk_req(REQ_MOVE, 0, 0, s, 1, s, 0, 0));
        for (int s = 1; s < MAX_HEIGHT; s = s * 2)
            send_req(mk_req(REQ_MOVE, 0, 0, MAX_WIDTH, s, 0, s, 0));

        send_req(mk_req(REQ_WRITE, 0, 0, 0, 0, 0, 0, 16'hFFFF));
        send_req(mk_req(REQ_WRITE, 63, 63, 0, 0, 0, 0, 16'h0000));
        send_req(mk_req(REQ_WRITE, -1, 0, 0, 0, 0, 0, 16'h1234));
        send_req(mk_req(REQ_WRITE, 64, 0, 0, 0, 0, 0, 16'h4321));
        send_req(mk_req(REQ_WRITE, 0, 64, 0, 0, 0, 0, 16'h5A5A));
        send_req(mk_req(REQ_WRITE, -32768, 32767, -1, -1, -1, -1, 16'h8001));
        send_req(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0));
        send_req(mk_req(REQ_READ, 63, 63, 0, 0, 0, 0, 0));
        send_req(mk_req(REQ_READ, 32767, -32768, 0, 0, 0, 0, 0));
        send_req(mk_req(REQ_READ, -1, 5, 0, 0, 0, 0, 0));
        send_req(mk_req(REQ_UNUSED, -1, -1, -1, -1, -1, -1, 16'hFFFF));
        send_req(mk_req(REQ_UNUSED, 5, 5, 4, 4, 0, 0, 16'h0000));
        // full screen onto itself
        send_req(mk_req(REQ_MOVE, 0, 0, 64, 64, 0, 0, 0));
        // overlapping moves, both directions
        send_req(mk_req(REQ_MOVE, 0, 0, 10, 10, 3, 2, 0));
        send_req(mk_req(REQ_MOVE, 5, 5, 10, 10, 2, 1, 0));
        // target or source off the left and top edges: copy still from the clipped source corner
        send_req(mk_req(REQ_MOVE, 10, 10, 8, 8, -3, -2, 0));
        send_req(mk_req(REQ_MOVE, -5, -5, 20, 20, 30, 30, 0));
        // full-width rows, then empty sources and source or target off the screen
        send_req(mk_req(REQ_MOVE, 0, 5, 64, 3, 0, 20, 0));
        send_req(mk_req(REQ_MOVE, 3, 3, 0, 5, 10, 10, 0));
        send_req(mk_req(REQ_MOVE, 3, 3, 5, -32768, 10, 10, 0));
        send_req(mk_req(REQ_MOVE, 100, 100, 5, 5, 0, 0, 0));
        send_req(mk_req(REQ_MOVE, 2, 2, 4, 4, 70, 0, 0));
        // sums past 16 bits must not wrap; then a target clipped at the right and bottom edges
        send_req(mk_req(REQ_MOVE, 32767, 32767, 32767, 32767, 0, 0, 0));
        send_req(mk_req(REQ_MOVE, -32768, -32768, 32767, 32767, -32768, 32767, 0));
        send_req(mk_req(REQ_MOVE, 60, 60, 10, 10, 62, 62, 0));
        send_req(mk_req(REQ_READ, 5, 5, 0, 0, 0, 0, 0));

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drain();
            if (p < 3) begin
                send_idle_pct = 32;
                recv_idle_pct = 77;
            end else if (p < 5) begin
                send_idle_pct = 77;
                recv_idle_pct = 32;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_screen_reg(REG_SCREEN_WIDTH, cfg_w[p]);
            write_screen_reg(REG_SCREEN_HEIGHT, cfg_h[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_req(random_req(cfg_w[p] > MAX_WIDTH ? MAX_WIDTH : cfg_w[p],
                                    cfg_h[p] > MAX_HEIGHT ? MAX_HEIGHT : cfg_h[p]));
        end

        wait_drain();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* clipped_rect_block_move_top.f */
rtl/core/crbm_pkg.sv
rtl/core/crbm_ctrl.sv
rtl/core/crbm_dp.sv
rtl/core/clipped_rect_block_move_top.sv
tb/crbm_result_checker.sv
tb/clipped_rect_block_move_top_tb.sv
